// File: sv/resonator_bank_body_filter_unit_macros.svh
//------------------------------------------------------------------------------
// Resonator bank body filter: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
//------------------------------------------------------------------------------
`ifndef RESONATOR_BANK_BODY_FILTER_UNIT_MACROS_SVH
`define RESONATOR_BANK_BODY_FILTER_UNIT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define RBBF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition holds in the cycle after the trigger.
`define RBBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/rbbf_pkg.sv
//------------------------------------------------------------------------------
// Resonator bank body filter: shared package
// Types, coefficient tables, register codes and rounding helpers.
//------------------------------------------------------------------------------
package rbbf_pkg;

	// Resonator slots that have coefficients.
	localparam int RES_SLOTS  = 4;
	localparam int RES_SLOT_W = 2;

	// Bandpass numerator b0 (b2 = -b0), signed Q2.22.
	localparam logic signed [20:0] RES_B0 [RES_SLOTS] = '{
		21'sd32531, 21'sd56204, 21'sd102754, 21'sd185678
	};
	// Negated feedback coefficients -a1 and -a2, signed Q2.22.
	localparam logic signed [24:0] RES_NA1 [RES_SLOTS] = '{
		25'sd8320250, 25'sd8255532, 25'sd8055661, 25'sd7446500
	};
	localparam logic signed [24:0] RES_NA2 [RES_SLOTS] = '{
		-25'sd4129242, -25'sd4081896, -25'sd3988796, -25'sd3822948
	};

	// Register reset values.
	localparam logic [13:0] DIRECT_GAIN_RST  = 14'd2253;
	localparam logic [13:0] BOX_GAIN_RST     = 14'd10650;
	localparam logic [13:0] WOOD_GAIN_RST    = 14'd8192;
	localparam logic [13:0] GRILLE_GAIN_RST  = 14'd6144;
	localparam logic [13:0] AIR_GAIN_RST     = 14'd3686;
	localparam logic [15:0] DC_POLE_RST      = 16'd65320;
	localparam logic [15:0] ROLLOFF_COEF_RST = 16'd37549;

	typedef enum logic [2:0] {
		REG_DIRECT_GAIN  = 3'd0,
		REG_BOX_GAIN     = 3'd1,
		REG_WOOD_GAIN    = 3'd2,
		REG_GRILLE_GAIN  = 3'd3,
		REG_AIR_GAIN     = 3'd4,
		REG_DC_POLE      = 3'd5,
		REG_ROLLOFF_COEF = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [13:0]                 direct_gain;
		logic [RES_SLOTS-1:0][13:0]  res_gain;
		logic [15:0]                 dc_pole;
		logic [15:0]                 rolloff_coef;
	} cfg_t;

	// Sequencer steps, one-hot.
	typedef enum logic [18:0] {
		S_IDLE   = 19'h00001,
		S_DIRECT = 19'h00002,
		S_R0     = 19'h00004,
		S_R1     = 19'h00008,
		S_R2     = 19'h00010,
		S_R3     = 19'h00020,
		S_R4     = 19'h00040,
		S_R5     = 19'h00080,
		S_R6     = 19'h00100,
		S_R7     = 19'h00200,
		S_T0     = 19'h00400,
		S_T1     = 19'h00800,
		S_T2     = 19'h01000,
		S_T3     = 19'h02000,
		S_T4     = 19'h04000,
		S_T5     = 19'h08000,
		S_T6     = 19'h10000,
		S_T7     = 19'h20000,
		S_T8     = 19'h40000
	} step_t;

	typedef struct packed {
		step_t step;
		logic  accept;
		logic  deliver;
	} seq_t;

	// Left shift applied to a product before it is accumulated.
	typedef enum logic [1:0] {
		SH_0  = 2'd0,
		SH_12 = 2'd1,
		SH_20 = 2'd2
	} shift_t;

	localparam int SPLIT_W = 20;

	typedef struct packed {
		logic               en;
		logic               load;
		logic signed [63:0] base;
		logic signed [24:0] a;
		logic signed [20:0] b;
		shift_t             sh;
	} mac_op_t;

	// floor((v + 2^(n-1)) / 2^n)
	function automatic logic signed [63:0] round_shr(input logic signed [63:0] v,
			input int unsigned n);
		logic signed [63:0] half;
		half = 64'sd1 <<< (n - 1);
		return (v + half) >>> n;
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
		logic signed [39:0] res;
		if (v[63:39] == {25{1'b0}} || v[63:39] == {25{1'b1}}) begin
			res = v[39:0];
		end else if (v[63]) begin
			res = {1'b1, {39{1'b0}}};
		end else begin
			res = {1'b0, {39{1'b1}}};
		end
		return res;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] res;
		if (v[63:31] == {33{1'b0}} || v[63:31] == {33{1'b1}}) begin
			res = v[31:0];
		end else if (v[63]) begin
			res = {1'b1, {31{1'b0}}};
		end else begin
			res = {1'b0, {31{1'b1}}};
		end
		return res;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
		logic signed [23:0] res;
		if (v[63:23] == {41{1'b0}} || v[63:23] == {41{1'b1}}) begin
			res = v[23:0];
		end else if (v[63]) begin
			res = {1'b1, {23{1'b0}}};
		end else begin
			res = {1'b0, {23{1'b1}}};
		end
		return res;
	endfunction

endpackage

// File: sv/resonator_bank_body_filter_unit.sv
//------------------------------------------------------------------------------
// Resonator bank body filter
// Bandpass resonator bank, DC blocker and lowpass on one shared MAC unit.
//------------------------------------------------------------------------------
// Usage: samples enter on the input channel (in_valid, in_stall, sample_in) and
// filtered samples leave on the output channel (out_valid, out_stall,
// sample_out). An item moves at a clock edge where valid is high and stall is
// low. Each item yields exactly one result item.
// Datapath: one shared 25 x 21 multiplier does every product, with 40-bit and
// 33-bit operands split into two halves. Each resonator takes eight sequencer
// steps, the direct path one and the DC blocker plus lowpass tail nine. Items
// are not overlapped: a new item is taken only in the idle step, once the last
// one has left the final step. in_stall is high while an item is in work.
// Output: the result sits in an output register. While the receiver stalls,
// the next item is still accepted and computed; its final step waits until
// the output register is free.
// Reset: asynchronous, active low. Registers return to their defaults and all
// filter state (resonator delays, blocker and lowpass memory) is cleared.
// Configuration writes take effect at once and belong between items.
//------------------------------------------------------------------------------
`include "resonator_bank_body_filter_unit_macros.svh"

module resonator_bank_body_filter_unit
	import rbbf_pkg::*;
#(
	parameter int NUM_RESONATORS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [23:0] sample_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] sample_out
);

	// Slots beyond the coefficient tables contribute nothing, so only the
	// populated ones are built.
	localparam int NUM_ACTIVE = (NUM_RESONATORS > RES_SLOTS) ? RES_SLOTS : NUM_RESONATORS;
	localparam int RES_IDX_W  = (NUM_ACTIVE > 1) ? $clog2(NUM_ACTIVE) : 1;

	cfg_t                 cfg;
	seq_t                 seq;
	logic [RES_IDX_W-1:0] res_idx;
	logic [RES_SLOT_W-1:0] slot;
	mac_op_t              mac_op;
	logic signed [63:0]   acc;
	logic                 out_free;

	// Sample-scoped working registers.
	logic signed [23:0] x_q;
	logic signed [42:0] bx_q;
	logic signed [39:0] r_q;
	logic signed [57:0] sum_q;
	logic signed [31:0] y_q;
	logic signed [32:0] diff_q;

	// Filter state.
	logic signed [39:0] d1_q [NUM_ACTIVE];
	logic signed [39:0] d2_q [NUM_ACTIVE];
	logic signed [31:0] bpi_q;
	logic signed [31:0] bpo_q;
	logic signed [31:0] lp_q;

	logic [23:0] out_q;
	logic        out_valid_q;

	logic signed [63:0] r_next;
	logic signed [31:0] hp_next;
	logic signed [32:0] y_minus_bpi;

	rbbf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	rbbf_ctrl #(
		.NUM_RES   (NUM_ACTIVE),
		.RES_IDX_W (RES_IDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.seq      (seq),
		.res_idx  (res_idx)
	);

	rbbf_mac u_mac (
		.clk (clk),
		.op  (mac_op),
		.acc (acc)
	);

	assign slot        = RES_SLOT_W'(res_idx);
	assign out_free    = !out_valid_q || !out_stall;
	assign y_minus_bpi = 33'(y_q) - 33'(bpi_q);

	// Operand selection for the shared unit. Wide operands go in two passes:
	// the low 20 bits unsigned, then the upper bits signed and shifted by 20.
	// Rounding offsets of the form round(P / 2^n) + c are folded in by loading
	// c * 2^n as the accumulator base.
	always_comb begin
		mac_op = '0;
		case (seq.step)
			S_DIRECT: begin
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.a    = 25'(x_q);
				mac_op.b    = {7'b0, cfg.direct_gain};
				mac_op.sh   = SH_12;
			end
			S_R0: begin
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.a    = 25'(x_q);
				mac_op.b    = RES_B0[slot];
			end
			S_R2: begin
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.base = 64'(d2_q[res_idx]) <<< 22;
				mac_op.a    = RES_NA1[slot];
				mac_op.b    = {1'b0, r_q[19:0]};
			end
			S_R3: begin
				mac_op.en = 1'b1;
				mac_op.a  = RES_NA1[slot];
				mac_op.b  = {r_q[39], r_q[39:20]};
				mac_op.sh = SH_20;
			end
			S_R4: begin
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.base = -(64'(bx_q) <<< 12);
				mac_op.a    = RES_NA2[slot];
				mac_op.b    = {1'b0, r_q[19:0]};
			end
			S_R5: begin
				mac_op.en = 1'b1;
				mac_op.a  = RES_NA2[slot];
				mac_op.b  = {r_q[39], r_q[39:20]};
				mac_op.sh = SH_20;
			end
			S_R6: begin
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.base = 64'(sum_q);
				mac_op.a    = {11'b0, cfg.res_gain[slot]};
				mac_op.b    = {1'b0, r_q[19:0]};
			end
			S_R7: begin
				mac_op.en = 1'b1;
				mac_op.a  = {11'b0, cfg.res_gain[slot]};
				mac_op.b  = {r_q[39], r_q[39:20]};
				mac_op.sh = SH_20;
			end
			S_T1: begin
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.base = 64'(y_minus_bpi) <<< 16;
				mac_op.a    = {9'b0, cfg.dc_pole};
				mac_op.b    = {1'b0, bpo_q[19:0]};
			end
			S_T2: begin
				mac_op.en = 1'b1;
				mac_op.a  = {9'b0, cfg.dc_pole};
				mac_op.b  = {{9{bpo_q[31]}}, bpo_q[31:20]};
				mac_op.sh = SH_20;
			end
			S_T5: begin
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.base = 64'(lp_q) <<< 16;
				mac_op.a    = {9'b0, cfg.rolloff_coef};
				mac_op.b    = {1'b0, diff_q[19:0]};
			end
			S_T6: begin
				mac_op.en = 1'b1;
				mac_op.a  = {9'b0, cfg.rolloff_coef};
				mac_op.b  = {{8{diff_q[32]}}, diff_q[32:20]};
				mac_op.sh = SH_20;
			end
			default: mac_op = '0;
		endcase
	end

	// Resonator output from b0 * x in Q.22 plus the first delay in Q.12.
	assign r_next  = round_shr(acc, 10) + 64'(d1_q[res_idx]);
	assign hp_next = sat32(round_shr(acc, 16));

	// Working registers carry no reset.
	always_ff @(posedge clk) begin
		if (seq.accept) begin
			x_q <= sample_in;
		end
		case (seq.step)
			S_R0: sum_q <= acc[57:0];
			S_R1: begin
				bx_q <= acc[42:0];
				r_q  <= sat40(r_next);
			end
			S_T0: y_q    <= sat32(round_shr(acc, 20));
			S_T4: diff_q <= 33'(bpo_q) - 33'(lp_q);
			default: ;
		endcase
	end

	// Filter state, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ACTIVE; i++) begin
				d1_q[i] <= '0;
				d2_q[i] <= '0;
			end
			bpi_q <= '0;
			bpo_q <= '0;
			lp_q  <= '0;
		end else begin
			case (seq.step)
				S_R4: d1_q[res_idx] <= sat40(round_shr(acc, 22));
				S_R6: d2_q[res_idx] <= sat40(round_shr(acc, 22));
				S_T3: begin
					bpi_q <= y_q;
					bpo_q <= hp_next;
				end
				S_T7: lp_q <= sat32(round_shr(acc, 16));
				default: ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (seq.deliver) begin
			out_q <= sat24(round_shr(64'(lp_q), 4));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq.deliver) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall   = (seq.step != S_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	// An accepted item always starts on the direct path.
	`RBBF_ASSERT_NEXT(a_accept_starts, seq.accept, seq.step == S_DIRECT, "accept did not start")
	// The resonator pass always begins at the first resonator.
	`RBBF_ASSERT_NEXT(a_first_res, seq.step == S_DIRECT, res_idx == '0, "resonator index not reset")
	// A full, stalled output register holds the sequencer in its final step.
	`RBBF_ASSERT_NEXT(a_hold_final, (seq.step == S_T8) && out_valid_q && out_stall, seq.step == S_T8, "final step left early")
	// A result is only written when the output register can take it.
	`RBBF_ASSERT_NOW(a_no_overwrite, seq.deliver, !out_valid_q || !out_stall, "pending result overwritten")

endmodule

// File: sv/rbbf_cfg.sv
//------------------------------------------------------------------------------
// Resonator bank body filter: configuration registers
// Write-only register file holding the gains and the tail coefficients.
//------------------------------------------------------------------------------
module rbbf_cfg
	import rbbf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direct_gain  <= DIRECT_GAIN_RST;
			cfg_q.res_gain[0]  <= BOX_GAIN_RST;
			cfg_q.res_gain[1]  <= WOOD_GAIN_RST;
			cfg_q.res_gain[2]  <= GRILLE_GAIN_RST;
			cfg_q.res_gain[3]  <= AIR_GAIN_RST;
			cfg_q.dc_pole      <= DC_POLE_RST;
			cfg_q.rolloff_coef <= ROLLOFF_COEF_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_DIRECT_GAIN:  cfg_q.direct_gain  <= wr_data[13:0];
				REG_BOX_GAIN:     cfg_q.res_gain[0]  <= wr_data[13:0];
				REG_WOOD_GAIN:    cfg_q.res_gain[1]  <= wr_data[13:0];
				REG_GRILLE_GAIN:  cfg_q.res_gain[2]  <= wr_data[13:0];
				REG_AIR_GAIN:     cfg_q.res_gain[3]  <= wr_data[13:0];
				REG_DC_POLE:      cfg_q.dc_pole      <= wr_data;
				REG_ROLLOFF_COEF: cfg_q.rolloff_coef <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/rbbf_mac.sv
//------------------------------------------------------------------------------
// Resonator bank body filter: shared multiply-accumulate unit
// One 25 x 21 signed multiplier, a selectable shift and a 64-bit accumulator.
//------------------------------------------------------------------------------
module rbbf_mac
	import rbbf_pkg::*;
(
	input  logic               clk,
	input  mac_op_t            op,
	output logic signed [63:0] acc
);

	logic signed [24:0] a_s;
	logic signed [20:0] b_s;
	logic signed [45:0] prod;
	logic signed [63:0] prod_ext;
	logic signed [63:0] prod_sh;
	logic signed [63:0] acc_q;

	assign a_s      = $signed(op.a);
	assign b_s      = $signed(op.b);
	assign prod     = a_s * b_s;
	assign prod_ext = 64'(prod);

	always_comb begin
		case (op.sh)
			SH_0:    prod_sh = prod_ext;
			SH_12:   prod_sh = prod_ext <<< 12;
			SH_20:   prod_sh = prod_ext <<< SPLIT_W;
			default: prod_sh = prod_ext;
		endcase
	end

	always_ff @(posedge clk) begin
		if (op.en) begin
			acc_q <= (op.load ? $signed(op.base) : acc_q) + prod_sh;
		end
	end

	assign acc = acc_q;

endmodule

// File: sv/rbbf_ctrl.sv
//------------------------------------------------------------------------------
// Resonator bank body filter: sequencer
// Steps one sample through the direct path, each resonator and the tail.
//------------------------------------------------------------------------------
module rbbf_ctrl
	import rbbf_pkg::*;
#(
	parameter int NUM_RES   = 4,
	parameter int RES_IDX_W = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_free,
	output seq_t                 seq,
	output logic [RES_IDX_W-1:0] res_idx
);

	localparam logic [RES_IDX_W-1:0] LAST_IDX = RES_IDX_W'(NUM_RES - 1);

	step_t                step_q, step_d;
	logic [RES_IDX_W-1:0] idx_q, idx_d;

	always_comb begin
		step_d = step_q;
		idx_d  = idx_q;
		case (step_q)
			S_IDLE: begin
				if (in_valid) begin
					step_d = S_DIRECT;
				end
			end
			S_DIRECT: begin
				step_d = S_R0;
				idx_d  = '0;
			end
			S_R0: step_d = S_R1;
			S_R1: step_d = S_R2;
			S_R2: step_d = S_R3;
			S_R3: step_d = S_R4;
			S_R4: step_d = S_R5;
			S_R5: step_d = S_R6;
			S_R6: step_d = S_R7;
			S_R7: begin
				if (idx_q == LAST_IDX) begin
					step_d = S_T0;
				end else begin
					step_d = S_R0;
					idx_d  = idx_q + 1'b1;
				end
			end
			S_T0: step_d = S_T1;
			S_T1: step_d = S_T2;
			S_T2: step_d = S_T3;
			S_T3: step_d = S_T4;
			S_T4: step_d = S_T5;
			S_T5: step_d = S_T6;
			S_T6: step_d = S_T7;
			S_T7: step_d = S_T8;
			S_T8: begin
				if (out_free) begin
					step_d = S_IDLE;
				end
			end
			default: step_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
			idx_q  <= '0;
		end else begin
			step_q <= step_d;
			idx_q  <= idx_d;
		end
	end

	assign seq.step    = step_q;
	assign seq.accept  = (step_q == S_IDLE) && in_valid;
	assign seq.deliver = (step_q == S_T8) && out_free;
	assign res_idx     = idx_q;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Resonator bank body filter: self-checking testbench
// Streams audio samples through the filter under random sender bursts and
// receiver stalls, including two long receiver hold-offs. A bit-exact model
// of the resonator bank, DC blocker and lowpass predicts every output sample.
// The model's register copy changes only between phases, while the filter
// is idle.
//------------------------------------------------------------------------------
module tb_top;
	import rbbf_pkg::*;

	localparam int RESONATORS = 4;
	localparam int unsigned RUN_LIMIT = 600000;
	localparam int TAIL_CYCLES = 80;

	// Index 7 is not a register; writes to it must be ignored.
	localparam logic [2:0] REG_UNUSED = 3'd7;

	// Bandpass coefficients, signed Q2.22; slots past the fourth are zero.
	localparam longint BP_B0 [8] = '{32531, 56204, 102754, 185678, 0, 0, 0, 0};
	localparam longint BP_A1 [8] = '{-8320250, -8255532, -8055661, -7446500,
		0, 0, 0, 0};
	localparam longint BP_A2 [8] = '{4129242, 4081896, 3988796, 3822948,
		0, 0, 0, 0};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [2:0]  wr_index = 3'd0;
	logic [15:0] wr_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [23:0] sample_in = 24'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [23:0] sample_out;

	resonator_bank_body_filter_unit #(
		.NUM_RESONATORS(RESONATORS)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Samples waiting to be offered, and filtered samples still owed by the block.
	logic [23:0] pending_samples [$];
	logic [23:0] owed_samples [$];

	int unsigned fail_count = 0;
	int unsigned results_seen = 0;
	// Items taken by the block, counted by the monitor; the driver keeps its
	// own copy of the last count it has seen.
	int unsigned taken_count = 0;
	int unsigned taken_seen = 0;

	// Model copy of the registers.
	longint gain_direct;
	longint gain_res [4];
	longint pole_coef;
	longint smooth_coef;

	// Model copy of the filter state.
	longint res_z1 [8];
	longint res_z2 [8];
	longint blk_prev_in;
	longint blk_prev_out;
	longint lp_acc;

	// Rounds half up: add half an LSB, then shift right arithmetically (floor).
	function automatic longint rnd_shr(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clamp_bits(longint v, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	task automatic model_defaults();
		gain_direct = DIRECT_GAIN_RST;
		gain_res[0] = BOX_GAIN_RST;
		gain_res[1] = WOOD_GAIN_RST;
		gain_res[2] = GRILLE_GAIN_RST;
		gain_res[3] = AIR_GAIN_RST;
		pole_coef = DC_POLE_RST;
		smooth_coef = ROLLOFF_COEF_RST;
		for (int i = 0; i < 8; i++) begin
			res_z1[i] = 0;
			res_z2[i] = 0;
		end
		blk_prev_in = 0;
		blk_prev_out = 0;
		lp_acc = 0;
	endtask

	// Filters one sample and advances the model state. Gains are Q2.12 and the
	// resonator outputs carry 12 fraction bits, so the sum is in Q.24; the tail
	// (blocker and lowpass) runs with 4 fraction bits.
	function automatic logic [23:0] filter_sample(logic signed [23:0] s);
		longint x;
		longint acc;
		longint bx;
		longint r;
		longint n1;
		longint n2;
		longint y;
		longint hp;
		longint lp;
		longint g;
		longint res;
		x = s;
		acc = x * gain_direct * 4096;
		for (int i = 0; i < RESONATORS; i++) begin
			g = (i < 4) ? gain_res[i] : 0;
			bx = BP_B0[i] * x;
			r = clamp_bits(rnd_shr(bx, 10) + res_z1[i], 40);
			n1 = rnd_shr(-BP_A1[i] * r, 22) + res_z2[i];
			n2 = rnd_shr(-bx * 4096 - BP_A2[i] * r, 22);
			res_z1[i] = clamp_bits(n1, 40);
			res_z2[i] = clamp_bits(n2, 40);
			acc += g * r;
		end
		y = clamp_bits(rnd_shr(acc, 20), 32);
		hp = clamp_bits(y - blk_prev_in + rnd_shr(pole_coef * blk_prev_out, 16), 32);
		blk_prev_in = y;
		blk_prev_out = hp;
		lp = lp_acc + rnd_shr((hp - lp_acc) * smooth_coef, 16);
		lp_acc = clamp_bits(lp, 32);
		res = clamp_bits(rnd_shr(lp_acc, 4), 24);
		return res[23:0];
	endfunction

	// Writes one register at the next edge and mirrors it into the model.
	// Gains keep only their low 14 bits; unknown indexes change nothing.
	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		case (idx)
			REG_DIRECT_GAIN:  gain_direct = data[13:0];
			REG_BOX_GAIN:     gain_res[0] = data[13:0];
			REG_WOOD_GAIN:    gain_res[1] = data[13:0];
			REG_GRILLE_GAIN:  gain_res[2] = data[13:0];
			REG_AIR_GAIN:     gain_res[3] = data[13:0];
			REG_DC_POLE:      pole_coef = data;
			REG_ROLLOFF_COEF: smooth_coef = data;
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Blocks until every queued sample has been taken and every result returned.
	task automatic wait_idle();
		while (pending_samples.size() != 0 || in_valid || owed_samples.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'd16383;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(60000, 65535));
			default: return 16'($urandom());
		endcase
	endfunction

	// Audio-like stimulus: segments of noise, quiet noise, square tones, steady
	// DC levels and lone impulses, each of random length and content.
	task automatic queue_audio(int count);
		int seg;
		int kind;
		int amp;
		int period;
		longint v;
		longint level;
		while (count > 0) begin
			seg = $urandom_range(8, 64);
			if (seg > count) begin
				seg = count;
			end
			kind = $urandom_range(0, 4);
			amp = $urandom_range(1, 8388607);
			period = $urandom_range(2, 240);
			level = longint'($urandom_range(0, 16777215)) - 8388608;
			for (int k = 0; k < seg; k++) begin
				case (kind)
					0: v = longint'($urandom_range(0, 16777215)) - 8388608;
					1: v = longint'($urandom_range(0, 2 * (amp >> 6) + 2)) - (amp >> 6) - 1;
					2: v = ((k % period) < period / 2) ? amp : -amp - 1;
					3: v = level;
					default: v = (k == 0) ? level : 0;
				endcase
				pending_samples.push_back(v[23:0]);
			end
			count -= seg;
		end
	endtask

	// Input driver: offers queued samples in bursts with random gaps between
	// them. A sample stays on the port until the block takes it.
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(negedge clk) begin
		logic        v_next;
		logic [23:0] d_next;
		v_next = in_valid;
		d_next = sample_in;
		if (!in_valid || taken_count != taken_seen) begin
			v_next = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_samples.size() > 0) begin
				d_next = pending_samples.pop_front();
				v_next = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end
				if (burst_left == 0) begin
					// A quarter of the bursts follow the previous one back to back.
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
					burst_left = $urandom_range(1, 24);
				end
			end
		end
		taken_seen = taken_count;
		in_valid <= v_next;
		sample_in <= d_next;
	end

	// Receiver: stall pattern changes mode every so often, and twice it holds
	// off long enough that the block backs up into its input.
	int unsigned mode_left = 0;
	int unsigned stall_mode = 0;
	int unsigned hold_left = 0;
	int unsigned holds_done = 0;
	int unsigned stall_tick = 0;

	always @(negedge clk) begin
		logic stall_next;
		stall_next = 1'b0;
		stall_tick++;
		if (hold_left > 0) begin
			hold_left--;
			stall_next = 1'b1;
		end else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 150 : 500)) begin
			holds_done++;
			hold_left = $urandom_range(250, 400);
			stall_next = 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (stall_mode)
				0: stall_next = 1'b0;
				1: stall_next = ($urandom_range(0, 3) == 0);
				2: stall_next = ($urandom_range(0, 3) != 0);
				default: stall_next = (stall_tick % 5 == 0);
			endcase
		end
		out_stall <= stall_next;
	end

	// Monitor: every sample the block takes is filtered by the model at once;
	// every output item is checked against the oldest owed sample.
	always @(posedge clk) begin
		logic [23:0] want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				owed_samples.push_back(filter_sample(sample_in));
				taken_count++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (owed_samples.size() == 0) begin
					fail_count++;
					$error("sample_out: unexpected item, expected none, actual %0d",
						$signed(sample_out));
				end else begin
					want = owed_samples.pop_front();
					if (sample_out !== want) begin
						fail_count++;
						$error("sample_out mismatch: expected %0d, actual %0d",
							$signed(want), $signed(sample_out));
					end
				end
			end
		end
	end

	// Watchdog: ends a run that hangs.
	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : main_seq
		bit missing;
		missing = 1'b0;
		model_defaults();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values: full-scale steps, both signs, tiny values, bit patterns.
		pending_samples = '{24'h000000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
			24'h800000, 24'h800000, 24'h000000, 24'h000001, 24'hFFFFFF,
			24'h555555, 24'hAAAAAA, 24'h000000, 24'h000000};
		wait_idle();

		// Every gain written with all 16 bits set, so only the low 14 stay;
		// pole and smoothing at one LSB below unity. A write to the spare
		// index must not disturb anything. Full-scale square drives saturation.
		write_reg(REG_DIRECT_GAIN, 16'hFFFF);
		write_reg(REG_BOX_GAIN, 16'hFFFF);
		write_reg(REG_WOOD_GAIN, 16'hFFFF);
		write_reg(REG_GRILLE_GAIN, 16'hFFFF);
		write_reg(REG_AIR_GAIN, 16'hFFFF);
		write_reg(REG_DC_POLE, 16'hFFFF);
		write_reg(REG_ROLLOFF_COEF, 16'hFFFF);
		write_reg(REG_UNUSED, 16'($urandom()));
		pending_samples = '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
			24'h7FFFFF, 24'h7FFFFF};
		wait_idle();

		// Everything at zero: no path reaches the sum and the lowpass freezes.
		write_reg(REG_DIRECT_GAIN, 16'd0);
		write_reg(REG_BOX_GAIN, 16'd0);
		write_reg(REG_WOOD_GAIN, 16'd0);
		write_reg(REG_GRILLE_GAIN, 16'd0);
		write_reg(REG_AIR_GAIN, 16'd0);
		write_reg(REG_DC_POLE, 16'd0);
		write_reg(REG_ROLLOFF_COEF, 16'd0);
		pending_samples = '{24'h7FFFFF, 24'h800000, 24'd100, 24'hFFFF9C};
		wait_idle();

		// Random phases; the third goes back to the reset settings.
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 2) begin
				write_reg(REG_DIRECT_GAIN, 16'(DIRECT_GAIN_RST));
				write_reg(REG_BOX_GAIN, 16'(BOX_GAIN_RST));
				write_reg(REG_WOOD_GAIN, 16'(WOOD_GAIN_RST));
				write_reg(REG_GRILLE_GAIN, 16'(GRILLE_GAIN_RST));
				write_reg(REG_AIR_GAIN, 16'(AIR_GAIN_RST));
				write_reg(REG_DC_POLE, DC_POLE_RST);
				write_reg(REG_ROLLOFF_COEF, ROLLOFF_COEF_RST);
			end else begin
				write_reg(REG_DIRECT_GAIN, pick_gain());
				write_reg(REG_BOX_GAIN, pick_gain());
				write_reg(REG_WOOD_GAIN, pick_gain());
				write_reg(REG_GRILLE_GAIN, pick_gain());
				write_reg(REG_AIR_GAIN, pick_gain());
				write_reg(REG_DC_POLE, pick_coef());
				write_reg(REG_ROLLOFF_COEF, pick_coef());
				if ($urandom_range(0, 1) == 0) begin
					write_reg(REG_UNUSED, 16'($urandom()));
				end
			end
			queue_audio(138);
			wait_idle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (owed_samples.size() != 0) begin
			missing = 1'b1;
			$error("sample_out: %0d expected items never arrived", owed_samples.size());
		end
		if (fail_count == 0 && !missing) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
